FILE: src/ffpa_pkg.sv
package ffpa_pkg;

	// Request operation codes.
	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_RESIZE = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_ADDR    = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_NO_ROOM = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] block_address;
		logic [31:0] request_bytes;
	} req_t;

	typedef struct packed {
		logic [31:0] result_address;
		logic [1:0]  status;
		logic        moved;
	} rsp_t;

endpackage

FILE: src/first_fit_page_allocator_unit.sv
// Channel | Signals                      | Direction
// req     | req_valid, req_stall, req    | in  (block drives req_stall)
// rsp     | rsp_valid, rsp_stall, rsp    | out (sink drives rsp_stall)
// cfg     | cfg_we, cfg_data (heap_base) | in, no read-back
//
// Each request runs a scan, a decision step, a commit pass and a finish step:
// the page table is a ring of cells, rotated to scan and again to write back.
// A new request is taken once the previous result is in the output register.
// arst_n clears the page table to all free and heap_base to zero.
// A stalled result holds in the output register; the next request is still
// taken and waits in its finishing step until that register is free.
module first_fit_page_allocator_unit #(
	parameter int PAGE_COUNT = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ffpa_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ffpa_pkg::rsp_t      rsp,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data
);
	import ffpa_pkg::*;

	localparam int EW = $clog2(PAGE_COUNT + 1);
	localparam int OW = $clog2(PAGE_COUNT) + $clog2(PAGE_BYTES) + 2;
	localparam logic [OW-1:0] PB_W  = OW'(PAGE_BYTES);
	localparam logic [EW-1:0] LAST  = EW'(PAGE_COUNT - 1);
	localparam logic [EW-1:0] NPAGE = EW'(PAGE_COUNT);

	typedef enum logic [2:0] {IDLE, SCAN, DECIDE, COMMIT, FINISH} state_t;

	state_t        state_q;
	logic [31:0]   base_q;
	req_t          req_q;
	logic [31:0]   d_q;
	logic [EW-1:0] pos_q;
	logic [OW-1:0] off_q;
	// First-fit search
	logic [EW-1:0] skip_q;
	logic [OW-1:0] run_bytes_q;
	logic [EW-1:0] run_cnt_q;
	logic          found_q;
	logic [EW-1:0] fstart_q;
	logic [EW-1:0] fend_q;
	logic [31:0]   faddr_q;
	// Existing block tracking
	logic          seen_s_q;
	logic          hit_q;
	logic [EW-1:0] spos_q;
	logic [EW-1:0] s_end_q;
	logic [OW-1:0] rel_q;
	logic [OW-1:0] cur_bytes_q;
	logic          cur_set_q;
	logic [EW-1:0] new_end_q;
	logic          new_end_set_q;
	logic          blocked_q;
	// Commit plan
	logic          wa_en_q;
	logic [EW-1:0] wa_page_q;
	logic [EW-1:0] wa_end_q;
	logic          wb_en_q;
	logic [EW-1:0] wb_page_q;
	rsp_t          res_q;
	rsp_t          rsp_q;
	logic          rsp_valid_q;

	logic          head_start, tail_start;
	logic [EW-1:0] head_end, tail_end;
	logic          shift;

	ffpa_ring #(.N(PAGE_COUNT), .EW(EW)) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.shift(shift),
		.tail_start(tail_start),
		.tail_end(tail_end),
		.head_start(head_start),
		.head_end(head_end)
	);

	assign shift = (state_q == SCAN) || (state_q == COMMIT);

	// Write-back of the head cell; changes land only in the commit pass.
	always_comb begin
		tail_start = head_start;
		tail_end   = head_end;
		if (state_q == COMMIT) begin
			if (wb_en_q && pos_q == wb_page_q) begin
				tail_start = 1'b0;
				tail_end   = pos_q + EW'(1);
			end
			if (wa_en_q && pos_q == wa_page_q) begin
				tail_start = 1'b1;
				tail_end   = wa_end_q;
			end
		end
	end

	// Scan helpers for the page at the head of the ring.
	logic [OW-1:0] bytes_w, d_w, cur_rel, run_next, rel_fin, cur_fin;
	logic [EW-1:0] cnt_next, new_end_fin;
	logic          in_page, tracking, can_look, d_fits;

	// Sizes beyond the offset range saturate, so they never fit in the heap.
	assign bytes_w  = ((req_q.request_bytes >> OW) != '0) ? '1 :
		OW'(req_q.request_bytes);
	assign d_fits   = (d_q >> OW) == '0;
	assign d_w      = OW'(d_q);
	assign in_page  = d_fits && (d_w >= off_q) && (d_w < off_q + PB_W);
	assign cur_rel  = in_page ? '0 : rel_q;
	assign tracking = in_page || seen_s_q;
	assign run_next = run_bytes_q + PB_W;
	assign cnt_next = run_cnt_q + EW'(1);
	assign can_look = !found_q && (pos_q >= skip_q);
	assign rel_fin  = rel_q;
	assign cur_fin  = cur_set_q ? cur_bytes_q : rel_q;
	assign new_end_fin = new_end_set_q ? new_end_q : NPAGE;

	// Decision after the scan pass.
	logic is_alloc, is_free, is_resize;
	logic          d_wa_en, d_wb_en;
	logic [EW-1:0] d_wa_page, d_wa_end, d_wb_page;
	rsp_t          d_res;

	always_comb begin
		is_alloc  = (req_q.mode == MODE_ALLOC) ||
			((req_q.mode == MODE_RESIZE) && (req_q.block_address == '0));
		is_free   = !is_alloc && ((req_q.mode == MODE_FREE) ||
			((req_q.mode == MODE_RESIZE) && (req_q.request_bytes == '0)));
		is_resize = !is_alloc && !is_free && (req_q.mode == MODE_RESIZE);
		d_wa_en   = 1'b0;
		d_wa_page = fstart_q;
		d_wa_end  = fend_q;
		d_wb_en   = 1'b0;
		d_wb_page = spos_q;
		d_res     = '{result_address: '0, status: ST_DONE, moved: 1'b0};
		if (is_alloc) begin
			if (found_q) begin
				d_wa_en = 1'b1;
				d_res   = '{result_address: faddr_q, status: ST_ADDR, moved: 1'b0};
			end else begin
				d_res.status = ST_NO_ROOM;
			end
		end else if (is_free) begin
			// A null address never names a block.
			d_wb_en = hit_q && (req_q.block_address != '0);
		end else if (is_resize) begin
			if (!hit_q) begin
				d_res.status = ST_NO_ROOM;
			end else if (bytes_w > cur_fin) begin
				if (!blocked_q && rel_fin >= bytes_w) begin
					d_wa_en   = 1'b1;
					d_wa_page = spos_q;
					d_wa_end  = new_end_fin;
					d_res = '{result_address: req_q.block_address, status: ST_ADDR,
						moved: 1'b0};
				end else if (found_q) begin
					d_wa_en = 1'b1;
					d_wb_en = 1'b1;
					d_res   = '{result_address: faddr_q, status: ST_ADDR, moved: 1'b1};
				end else begin
					d_res.status = ST_NO_ROOM;
				end
			end else begin
				d_wa_en   = 1'b1;
				d_wa_page = spos_q;
				d_wa_end  = new_end_fin;
				d_res = '{result_address: req_q.block_address, status: ST_ADDR,
					moved: 1'b0};
			end
		end
	end

	// Sequencer, scan registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			base_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						req_q         <= req;
						d_q           <= req.block_address - base_q;
						pos_q         <= '0;
						off_q         <= '0;
						skip_q        <= '0;
						run_bytes_q   <= '0;
						run_cnt_q     <= '0;
						found_q       <= 1'b0;
						seen_s_q      <= 1'b0;
						hit_q         <= 1'b0;
						rel_q         <= '0;
						cur_set_q     <= 1'b0;
						new_end_set_q <= 1'b0;
						blocked_q     <= 1'b0;
						state_q       <= SCAN;
					end
				end
				SCAN: begin
					// First-fit run search over pages in order.
					if (can_look) begin
						if (head_start) begin
							skip_q      <= head_end;
							run_bytes_q <= '0;
							run_cnt_q   <= '0;
						end else begin
							run_bytes_q <= run_next;
							run_cnt_q   <= cnt_next;
							if (req_q.request_bytes != '0 && run_next >= bytes_w) begin
								found_q  <= 1'b1;
								fstart_q <= pos_q - run_cnt_q;
								fend_q   <= pos_q + EW'(1);
								faddr_q  <= base_q + 32'(off_q + PB_W - run_next);
							end
						end
					end
					// Existing block: capture it and watch the pages after it.
					if (in_page) begin
						seen_s_q <= 1'b1;
						hit_q    <= head_start;
						spos_q   <= pos_q;
						s_end_q  <= head_end;
					end
					if (seen_s_q) begin
						if (!cur_set_q && pos_q == s_end_q) begin
							cur_bytes_q <= cur_rel;
							cur_set_q   <= 1'b1;
						end
						if (!new_end_set_q && cur_rel >= bytes_w) begin
							new_end_q     <= pos_q;
							new_end_set_q <= 1'b1;
						end
						if (pos_q >= s_end_q && cur_rel < bytes_w && head_start) begin
							blocked_q <= 1'b1;
						end
					end
					if (tracking) begin
						rel_q <= cur_rel + PB_W;
					end
					off_q <= off_q + PB_W;
					if (pos_q == LAST) begin
						pos_q   <= '0;
						state_q <= DECIDE;
					end else begin
						pos_q <= pos_q + EW'(1);
					end
				end
				DECIDE: begin
					wa_en_q   <= d_wa_en;
					wa_page_q <= d_wa_page;
					wa_end_q  <= d_wa_end;
					wb_en_q   <= d_wb_en;
					wb_page_q <= d_wb_page;
					res_q     <= d_res;
					state_q   <= COMMIT;
				end
				COMMIT: begin
					if (pos_q == LAST) begin
						pos_q   <= '0;
						state_q <= FINISH;
					end else begin
						pos_q <= pos_q + EW'(1);
					end
				end
				FINISH: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// A result appears only out of the finishing step.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == FINISH))
		else $error("result raised outside finish step");

	// A relocated block always comes with an address.
	a_moved_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.moved |-> rsp.status == ST_ADDR)
		else $error("moved without address");

	// Results without an address carry a zero address.
	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_ADDR |-> rsp.result_address == '0)
		else $error("nonzero address on failed result");

	// An accepted request keeps the input stalled while it is worked on.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input not stalled after transfer");
`endif

endmodule

FILE: src/ffpa_cell.sv
module ffpa_cell #(
	parameter int EW = 9,
	parameter logic [EW-1:0] RESET_END = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          start_in,
	input  logic [EW-1:0] end_in,
	output logic          start_out,
	output logic [EW-1:0] end_out
);
	import ffpa_pkg::*;

	logic          start_q;
	logic [EW-1:0] end_q;

	// One page entry; it takes its neighbor's entry on every shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			end_q   <= RESET_END;
		end else if (shift) begin
			start_q <= start_in;
			end_q   <= end_in;
		end
	end

	assign start_out = start_q;
	assign end_out   = end_q;

endmodule

FILE: src/ffpa_ring.sv
module ffpa_ring #(
	parameter int N  = 256,
	parameter int EW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  logic          tail_start,
	input  logic [EW-1:0] tail_end,
	output logic          head_start,
	output logic [EW-1:0] head_end
);
	import ffpa_pkg::*;

	logic          st [N];
	logic [EW-1:0] en [N];

	// Cell i receives from cell i+1; the last cell receives the write-back value.
	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          nxt_start;
		logic [EW-1:0] nxt_end;
		if (i == N - 1) begin : g_tail
			assign nxt_start = tail_start;
			assign nxt_end   = tail_end;
		end else begin : g_mid
			assign nxt_start = st[i+1];
			assign nxt_end   = en[i+1];
		end
		ffpa_cell #(
			.EW(EW),
			.RESET_END(EW'(i + 1))
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.shift(shift),
			.start_in(nxt_start),
			.end_in(nxt_end),
			.start_out(st[i]),
			.end_out(en[i])
		);
	end

	assign head_start = st[0];
	assign head_end   = en[0];

endmodule

FILE: tb/sv/ffpa_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and configuration ports of the allocator.
// It keeps its own page table, predicts one result per request and compares.
module ffpa_checker #(
	parameter int PAGE_COUNT = 256,
	parameter int PAGE_BYTES = 4096
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  ffpa_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  ffpa_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_data,
	output int             fail_count,
	output int             pending_count
);
	import ffpa_pkg::*;

	// Predicted page table and heap base.
	bit          block_starts[PAGE_COUNT];
	int unsigned block_end[PAGE_COUNT];
	logic [31:0] base_addr;
	rsp_t        expected_rsp_q[$];

	function automatic int unsigned pages_needed(logic [31:0] bytes);
		return bytes / PAGE_BYTES + ((bytes % PAGE_BYTES) != 0);
	endfunction

	function automatic logic [31:0] addr_of_page(int unsigned page);
		return base_addr + page * PAGE_BYTES;
	endfunction

	// Returns the start page of the block at an address, or -1.
	function automatic int start_page_of(logic [31:0] addr);
		logic [31:0] idx;
		idx = (addr - base_addr) / PAGE_BYTES;
		if (idx >= PAGE_COUNT || !block_starts[idx])
			return -1;
		return idx;
	endfunction

	function automatic void free_block(int unsigned page);
		block_starts[page] = 0;
		block_end[page] = page + 1;
	endfunction

	// First-fit search; returns the new start page or -1.
	function automatic int take_run(logic [31:0] bytes);
		int unsigned pages, pos, run;
		pages = pages_needed(bytes);
		pos = 0;
		run = 0;
		if (pages == 0 || pages > PAGE_COUNT)
			return -1;
		while (pos < PAGE_COUNT) begin
			if (block_starts[pos]) begin
				pos = (block_end[pos] > pos) ? block_end[pos] : pos + 1;
				run = 0;
			end else begin
				run++;
				if (run == pages) begin
					block_starts[pos + 1 - pages] = 1;
					block_end[pos + 1 - pages] = pos + 1;
					return pos + 1 - pages;
				end
				pos++;
			end
		end
		return -1;
	endfunction

	function automatic rsp_t make_rsp(logic [31:0] a, logic [1:0] st, logic mv);
		rsp_t r;
		r.result_address = a;
		r.status = st;
		r.moved = mv;
		return r;
	endfunction

	// Applies one request to the table and returns the expected result.
	function automatic rsp_t predict_request(req_t rq);
		int p, s;
		int unsigned need, cur, e;
		bit ok;
		if (rq.mode == MODE_ALLOC || (rq.mode == MODE_RESIZE && rq.block_address == 0)) begin
			p = take_run(rq.request_bytes);
			if (p >= 0)
				return make_rsp(addr_of_page(p), ST_ADDR, 1'b0);
			return make_rsp('0, ST_NO_ROOM, 1'b0);
		end
		if (rq.mode == MODE_FREE || (rq.mode == MODE_RESIZE && rq.request_bytes == 0)) begin
			if (rq.block_address != 0) begin
				p = start_page_of(rq.block_address);
				if (p >= 0)
					free_block(p);
			end
			return make_rsp('0, ST_DONE, 1'b0);
		end
		if (rq.mode != MODE_RESIZE)
			return make_rsp('0, ST_DONE, 1'b0);
		s = start_page_of(rq.block_address);
		if (s < 0)
			return make_rsp('0, ST_NO_ROOM, 1'b0);
		need = pages_needed(rq.request_bytes);
		e = block_end[s];
		cur = e - s;
		if (need > cur) begin
			ok = (longint'(s) + need) <= PAGE_COUNT;
			for (int unsigned i = e; ok && i < s + need; i++)
				if (block_starts[i])
					ok = 0;
			if (ok) begin
				block_end[s] = s + need;
				return make_rsp(rq.block_address, ST_ADDR, 1'b0);
			end
			p = take_run(rq.request_bytes);
			if (p < 0)
				return make_rsp('0, ST_NO_ROOM, 1'b0);
			free_block(s);
			return make_rsp(addr_of_page(p), ST_ADDR, 1'b1);
		end
		if (need < cur)
			block_end[s] = s + need;
		return make_rsp(rq.block_address, ST_ADDR, 1'b0);
	endfunction

	// Tracks transfers on every port at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < PAGE_COUNT; i++)
				free_block(i);
			base_addr = '0;
			expected_rsp_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				base_addr = cfg_data;
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result %p", $realtime, rsp);
				end else begin
					want = expected_rsp_q.pop_front();
					if (rsp.result_address !== want.result_address ||
							rsp.status !== want.status || rsp.moved !== want.moved) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: result mismatch expected %p actual %p",
								$realtime, want, rsp);
					end
				end
			end
			if (req_valid && !req_stall)
				expected_rsp_q.push_back(predict_request(req));
		end
		pending_count = expected_rsp_q.size();
	end
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import ffpa_pkg::*;

	localparam int PAGES = 256;
	localparam int PBYTES = 4096;
	localparam int SCAN_CYCLES = 2 * PAGES + 2;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 0;
	rsp_t        rsp;
	logic        cfg_we = 0;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          pending_count;

	// Candidate block addresses on page boundaries, reused for free and resize.
	logic [31:0] live_blocks[$];
	logic [31:0] heap_base_now;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	first_fit_page_allocator_unit #(.PAGE_COUNT(PAGES), .PAGE_BYTES(PBYTES)) dut (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
		.cfg_we, .cfg_data
	);

	ffpa_checker #(.PAGE_COUNT(PAGES), .PAGE_BYTES(PBYTES)) checker_i (
		.clk, .arst_n, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
		.cfg_we, .cfg_data, .fail_count, .pending_count
	);

	// Sends one request after a random gap and waits for its transfer.
	// Valid drops only for a gap before a request, so back-to-back items keep it high.
	task automatic send_request(logic [1:0] m, logic [31:0] a, logic [31:0] b);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1;
		req.mode <= m;
		req.block_address <= a;
		req.request_bytes <= b;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// Waits until every result is in, then lets the block settle.
	task automatic drain_results();
		req_valid <= 0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SCAN_CYCLES + 8) @(negedge clk);
	endtask

	task automatic write_base(logic [31:0] value);
		drain_results();
		cfg_we <= 1;
		cfg_data <= value;
		heap_base_now = value;
		@(negedge clk);
		cfg_we <= 0;
		live_blocks.delete();
	endtask

	// Random byte count, mostly a few pages.
	function automatic logic [31:0] rand_bytes();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom();
			2: return $urandom_range(PAGES * PBYTES - 64, PAGES * PBYTES + 64);
			default: return $urandom_range(1, 12 * PBYTES);
		endcase
	endfunction

	// Picks an address: a live block, an offset into one, null or noise.
	function automatic logic [31:0] pick_address();
		int k;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom();
			2: return heap_base_now + $urandom_range(0, PAGES * PBYTES);
			default: begin
				if (live_blocks.size() == 0)
					return heap_base_now;
				k = $urandom_range(0, live_blocks.size() - 1);
				return live_blocks[k] + ($urandom_range(0, 3) == 0 ?
					$urandom_range(0, PBYTES - 1) : 0);
			end
		endcase
	endfunction

	task automatic random_phase(int count);
		logic [1:0] m;
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			m = r < 8 ? MODE_ALLOC : (r < 13 ? MODE_FREE : (r < 19 ? MODE_RESIZE : MODE_NONE));
			send_request(m, pick_address(), rand_bytes());
			if (m == MODE_ALLOC && live_blocks.size() < 64)
				live_blocks.push_back(heap_base_now +
					$urandom_range(0, PAGES - 1) * PBYTES);
		end
	endtask

	// The sink stalls for a random count before each result.
	initial begin
		int hold;
		forever begin
			@(negedge clk);
			if (rsp_valid && rsp_stall == 0) begin
				hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 16);
				if (hold > 0) begin
					rsp_stall <= 1;
					repeat (hold) @(negedge clk);
					rsp_stall <= 0;
				end
				@(negedge clk);
			end
		end
	end

	initial begin
		#300_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		heap_base_now = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, every mode and the corner cases.
		send_request(MODE_ALLOC, 0, 0);
		send_request(MODE_ALLOC, 0, 1);
		send_request(MODE_FREE, 0, 0);
		send_request(MODE_ALLOC, 0, PBYTES + 1);
		send_request(MODE_RESIZE, 0, PBYTES);
		send_request(MODE_ALLOC, 0, 32'hFFFF_FFFF);
		send_request(MODE_ALLOC, 0, PAGES * PBYTES);
		send_request(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(MODE_FREE, PBYTES, 0);
		send_request(MODE_RESIZE, PBYTES * 3, 0);
		send_request(MODE_RESIZE, 32'hFFFF_FFFF, 5);
		send_request(MODE_ALLOC, 0, 2 * PBYTES);
		send_request(MODE_RESIZE, PBYTES * 4, 5 * PBYTES);
		send_request(MODE_RESIZE, PBYTES * 4, PBYTES);
		send_request(MODE_ALLOC, 0, PBYTES);
		send_request(MODE_RESIZE, PBYTES * 4, 200 * PBYTES);
		send_request(MODE_RESIZE, PBYTES * 4, 250 * PBYTES);
		send_request(MODE_ALLOC, 0, 3 * PBYTES);
		send_request(MODE_RESIZE, 32'hFFFF_F000, 2 * PBYTES);

		// Random phases under several heap bases, the extremes among them.
		write_base(32'hFFFF_FFFF);
		random_phase(200);
		write_base(32'hFFF8_0000);
		random_phase(250);
		write_base($urandom());
		random_phase(250);
		write_base(32'h0000_0000);
		random_phase(200);
		drain_results();
		write_base(32'h1000_0000);
		random_phase(200);
		drain_results();

		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
